// ===== sv/mapid_pkg.sv =====
// ----------------------------------------------------------------------------
// mapid_pkg
// Types, widths and constants shared by the motor angle PID controller.
// ----------------------------------------------------------------------------
package mapid_pkg;

    localparam int DIV_W     = 32;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int ERR_W     = 24;
    localparam int DIFF_W    = 25;
    localparam int MUL_A_W   = 26;
    localparam int PROD_W    = 42;
    localparam int INTEG_W   = 48;
    localparam int IB_W      = 44;
    localparam int IB_SPLIT  = 22;
    localparam int ACC_W     = 61;
    localparam int SUM_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;
    localparam logic signed [INTEG_W-1:0] IB_POS    = 48'sh0400_0000_0000;
    localparam logic signed [INTEG_W-1:0] IB_NEG    = 48'shFC00_0000_0000;
    localparam logic signed [SUM_W-1:0]   OUT_LIM   = 25'sd16776960;
    localparam logic signed [SUM_W-1:0]   ROUND_ADJ = 25'sd255;
    localparam logic [DEN_W-1:0]          DEG_PER_REV = 16'd360;

    localparam logic [15:0] RST_GAIN_P  = 16'd256;
    localparam logic [15:0] RST_GAIN_I  = 16'd0;
    localparam logic [15:0] RST_GAIN_D  = 16'd0;
    localparam logic [15:0] RST_TGT_ANG = 16'd0;
    localparam logic [15:0] RST_PPR     = 16'd360;
    localparam logic [15:0] RST_MIN_DTY = 16'd0;
    localparam logic [15:0] RST_MAX_DTY = 16'd65535;
    localparam logic [31:0] RST_ZERO_TO = 32'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_ANG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DTY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DTY = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TO = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT_MUL,
        ST_TGT_DIV,
        ST_TGT_WAIT,
        ST_ERR,
        ST_INTEG,
        ST_DER_WAIT,
        ST_MUL_P,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_MUL_D,
        ST_ACC_D,
        ST_CLAMP,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TGT,
        MUL_ERR,
        MUL_P,
        MUL_ILO,
        MUL_IHI,
        MUL_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } t_acc_op;

    typedef enum logic {
        DIV_TGT,
        DIV_DER
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     div_start;
        t_div_sel div_sel;
        logic     err_load;
        logic     integ_load;
        logic     d_load;
        logic     clamp_load;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic dt_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/mapid_div.sv =====
// ----------------------------------------------------------------------------
// mapid_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module mapid_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mapid_pkg::DIV_W-1:0]   i_dividend,
    input  logic [mapid_pkg::DEN_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [mapid_pkg::DIV_W-1:0]   o_quotient
);

    localparam int DW    = mapid_pkg::DIV_W;
    localparam int NW    = mapid_pkg::DEN_W;
    localparam int CNT_W = $clog2(mapid_pkg::DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_den;
    logic [DW-1:0]    r_quo;

    logic [NW:0]      w_r1;
    logic [NW:0]      w_r2;
    logic             w_g1;
    logic             w_g2;
    logic [NW-1:0]    w_rem1;
    logic [NW-1:0]    w_rem2;
    logic [DW-1:0]    w_quo1;
    logic [DW-1:0]    w_quo2;

    always_comb begin
        w_r1   = {r_rem, r_quo[DW-1]};
        w_g1   = (w_r1 >= {1'b0, r_den});
        w_rem1 = w_g1 ? NW'(w_r1 - {1'b0, r_den}) : w_r1[NW-1:0];
        w_quo1 = {r_quo[DW-2:0], w_g1};
        w_r2   = {w_rem1, w_quo1[DW-1]};
        w_g2   = (w_r2 >= {1'b0, r_den});
        w_rem2 = w_g2 ? NW'(w_r2 - {1'b0, r_den}) : w_r2[NW-1:0];
        w_quo2 = {w_quo1[DW-2:0], w_g2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(mapid_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_quo <= w_quo2;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/mapid_dp.sv =====
// ----------------------------------------------------------------------------
// mapid_dp
// Datapath: config registers, shared multiplier, accumulator, integral,
// divider and output register.
// ----------------------------------------------------------------------------
module mapid_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr,
    input  logic [mapid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic [15:0]                       i_enc,
    input  logic [15:0]                       i_now,
    input  logic                              i_m_tready,
    input  mapid_pkg::t_cmd                   i_cmd,
    output mapid_pkg::t_sts                   o_sts,
    output logic                              o_m_tvalid,
    output logic [mapid_pkg::M_DATA_W-1:0]    o_m_tdata
);

    localparam int EW = mapid_pkg::ERR_W;
    localparam int FW = mapid_pkg::DIFF_W;
    localparam int AW = mapid_pkg::MUL_A_W;
    localparam int PW = mapid_pkg::PROD_W;
    localparam int IW = mapid_pkg::INTEG_W;
    localparam int BW = mapid_pkg::IB_W;
    localparam int SP = mapid_pkg::IB_SPLIT;
    localparam int CW = mapid_pkg::ACC_W;
    localparam int UW = mapid_pkg::SUM_W;

    // config
    logic [15:0]        r_gain_p;
    logic [15:0]        r_gain_i;
    logic [15:0]        r_gain_d;
    logic [15:0]        r_tgt_ang;
    logic [15:0]        r_ppr;
    logic [15:0]        r_min_dty;
    logic [15:0]        r_max_dty;
    logic [31:0]        r_zero_to;

    // controller state carried between items
    logic signed [EW-1:0] r_prev_err;
    logic signed [IW-1:0] r_integ;
    logic [15:0]          r_prev_time;
    logic [15:0]          r_last_zero;

    // per-item working registers
    logic [15:0]          r_enc;
    logic [15:0]          r_now;
    logic [15:0]          r_dt;
    logic                 r_dt_zero;
    logic signed [PW-1:0] r_prod;
    logic                 r_qneg;
    logic signed [EW-1:0] r_err;
    logic signed [FW-1:0] r_deriv;
    logic signed [CW-1:0] r_acc;
    logic signed [UW-1:0] r_sum;
    logic                 r_zero;

    logic                 r_m_tvalid;
    logic [mapid_pkg::M_DATA_W-1:0] r_m_tdata;

    logic signed [AW-1:0]   w_mul_a;
    logic [15:0]            w_mul_b;
    logic signed [PW:0]     w_mul_full;
    logic signed [PW-1:0]   w_prod_abs;
    logic signed [FW-1:0]   w_diff;
    logic [FW-1:0]          w_diff_abs;
    logic [mapid_pkg::DIV_W-1:0] w_dividend;
    logic [mapid_pkg::DEN_W-1:0] w_divisor;
    logic                   w_div_neg;
    logic                   w_div_done;
    logic [mapid_pkg::DIV_W-1:0] w_quo;
    logic signed [EW-1:0]   w_q_tgt;
    logic signed [FW-1:0]   w_q_der;
    logic signed [IW:0]     w_isum;
    logic signed [BW-1:0]   w_ib;
    logic signed [UW-1:0]   w_round;
    logic signed [16:0]     w_y;
    logic [16:0]            w_mag;
    logic [15:0]            w_duty_lo;
    logic [15:0]            w_duty;
    logic                   w_dir_a;
    logic                   w_dir_b;
    logic [15:0]            w_lz_new;
    logic [15:0]            w_since;
    logic                   w_settled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= mapid_pkg::RST_GAIN_P;
            r_gain_i  <= mapid_pkg::RST_GAIN_I;
            r_gain_d  <= mapid_pkg::RST_GAIN_D;
            r_tgt_ang <= mapid_pkg::RST_TGT_ANG;
            r_ppr     <= mapid_pkg::RST_PPR;
            r_min_dty <= mapid_pkg::RST_MIN_DTY;
            r_max_dty <= mapid_pkg::RST_MAX_DTY;
            r_zero_to <= mapid_pkg::RST_ZERO_TO;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                mapid_pkg::CFG_GAIN_P:  r_gain_p  <= i_cfg_data[15:0];
                mapid_pkg::CFG_GAIN_I:  r_gain_i  <= i_cfg_data[15:0];
                mapid_pkg::CFG_GAIN_D:  r_gain_d  <= i_cfg_data[15:0];
                mapid_pkg::CFG_TGT_ANG: r_tgt_ang <= i_cfg_data[15:0];
                mapid_pkg::CFG_PPR:     r_ppr     <= i_cfg_data[15:0];
                mapid_pkg::CFG_MIN_DTY: r_min_dty <= i_cfg_data[15:0];
                mapid_pkg::CFG_MAX_DTY: r_max_dty <= i_cfg_data[15:0];
                mapid_pkg::CFG_ZERO_TO: r_zero_to <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            mapid_pkg::MUL_TGT: begin
                w_mul_a = AW'($signed(r_tgt_ang));
                w_mul_b = r_ppr;
            end
            mapid_pkg::MUL_ERR: begin
                w_mul_a = AW'(r_err);
                w_mul_b = r_dt;
            end
            mapid_pkg::MUL_P: begin
                w_mul_a = AW'(r_err);
                w_mul_b = r_gain_p;
            end
            mapid_pkg::MUL_ILO: begin
                w_mul_a = AW'($signed({1'b0, w_ib[SP-1:0]}));
                w_mul_b = r_gain_i;
            end
            mapid_pkg::MUL_IHI: begin
                w_mul_a = AW'($signed(w_ib[BW-1:SP]));
                w_mul_b = r_gain_i;
            end
            mapid_pkg::MUL_D: begin
                w_mul_a = AW'(r_deriv);
                w_mul_b = r_gain_d;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_full = w_mul_a * $signed({1'b0, w_mul_b});

    // divider operands: magnitudes, sign restored on the quotient
    assign w_prod_abs = r_prod[PW-1] ? -r_prod : r_prod;
    assign w_diff     = FW'(r_err) - FW'(r_prev_err);
    assign w_diff_abs = w_diff[FW-1] ? FW'(-w_diff) : w_diff;

    always_comb begin
        if (i_cmd.div_sel == mapid_pkg::DIV_TGT) begin
            w_dividend = w_prod_abs[mapid_pkg::DIV_W-1:0];
            w_divisor  = mapid_pkg::DEG_PER_REV;
            w_div_neg  = r_prod[PW-1];
        end else begin
            w_dividend = mapid_pkg::DIV_W'(w_diff_abs);
            w_divisor  = r_dt;
            w_div_neg  = w_diff[FW-1];
        end
    end

    mapid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_q_tgt = r_qneg ? -$signed(w_quo[EW-1:0]) : $signed(w_quo[EW-1:0]);
    assign w_q_der = r_qneg ? -$signed(w_quo[FW-1:0]) : $signed(w_quo[FW-1:0]);

    // integral update with saturation, then bound for the gain product
    assign w_isum = $signed({r_integ[IW-1], r_integ}) + (IW + 1)'(r_prod);

    always_comb begin
        if (r_integ > mapid_pkg::IB_POS) begin
            w_ib = BW'(mapid_pkg::IB_POS);
        end else if (r_integ < mapid_pkg::IB_NEG) begin
            w_ib = BW'(mapid_pkg::IB_NEG);
        end else begin
            w_ib = r_integ[BW-1:0];
        end
    end

    // output stage: Q16.8 to whole units, direction, duty limits, settle window
    assign w_round = r_sum + (r_sum[UW-1] ? mapid_pkg::ROUND_ADJ : '0);
    assign w_y     = w_round[UW-1:8];
    assign w_mag   = w_y[16] ? 17'(-w_y) : w_y;

    always_comb begin
        if (w_y == '0) begin
            w_dir_a = 1'b1;
            w_dir_b = 1'b1;
        end else if (w_y[16]) begin
            w_dir_a = 1'b0;
            w_dir_b = 1'b1;
        end else begin
            w_dir_a = 1'b1;
            w_dir_b = 1'b0;
        end
    end

    assign w_duty_lo = (w_mag[15:0] < r_min_dty) ? r_min_dty : w_mag[15:0];
    assign w_duty    = (w_duty_lo > r_max_dty) ? r_max_dty : w_duty_lo;
    assign w_lz_new  = r_zero ? r_now : r_last_zero;
    assign w_since   = r_now - w_lz_new;
    assign w_settled = ({16'd0, w_since} < r_zero_to);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_integ     <= '0;
            r_prev_time <= '0;
            r_last_zero <= '0;
            r_m_tvalid  <= 1'b0;
        end else begin
            if (i_cmd.integ_load) begin
                if (w_isum[IW] != w_isum[IW-1]) begin
                    r_integ <= w_isum[IW] ? mapid_pkg::INTEG_MIN : mapid_pkg::INTEG_MAX;
                end else begin
                    r_integ <= w_isum[IW-1:0];
                end
            end
            if (i_cmd.out_load) begin
                r_prev_err  <= r_err;
                r_prev_time <= r_now;
                r_last_zero <= w_lz_new;
                r_m_tvalid  <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_enc     <= i_enc;
            r_now     <= i_now;
            r_dt      <= i_now - r_prev_time;
            r_dt_zero <= (i_now == r_prev_time);
        end
        if (i_cmd.mul_sel != mapid_pkg::MUL_NONE) begin
            r_prod <= w_mul_full[PW-1:0];
        end
        if (i_cmd.div_start) begin
            r_qneg <= w_div_neg;
        end
        if (i_cmd.err_load) begin
            r_err <= EW'(w_q_tgt - $signed({1'b0, r_enc}));
        end
        if (i_cmd.d_load) begin
            r_deriv <= r_dt_zero ? '0 : w_q_der;
        end
        case (i_cmd.acc_op)
            mapid_pkg::ACC_LOAD:   r_acc <= CW'(r_prod);
            mapid_pkg::ACC_ADD:    r_acc <= r_acc + CW'(r_prod);
            mapid_pkg::ACC_ADD_HI: r_acc <= r_acc + (CW'(r_prod) <<< SP);
            default: begin
            end
        endcase
        if (i_cmd.clamp_load) begin
            if (r_acc > CW'(mapid_pkg::OUT_LIM)) begin
                r_sum <= mapid_pkg::OUT_LIM;
            end else if (r_acc < -CW'(mapid_pkg::OUT_LIM)) begin
                r_sum <= -mapid_pkg::OUT_LIM;
            end else begin
                r_sum <= r_acc[UW-1:0];
            end
            r_zero <= (r_acc == '0);
        end
        if (i_cmd.out_load) begin
            r_m_tdata <= {5'd0, w_settled, w_duty, w_dir_b, w_dir_a};
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.dt_zero  = r_dt_zero;
    assign o_sts.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid     = r_m_tvalid;
    assign o_m_tdata      = r_m_tdata;

endmodule

// ===== sv/mapid_ctrl.sv =====
// ----------------------------------------------------------------------------
// mapid_ctrl
// Sequencer: steps one control tick through the datapath.
// ----------------------------------------------------------------------------
module mapid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mapid_pkg::t_sts i_sts,
    output mapid_pkg::t_cmd o_cmd
);

    mapid_pkg::t_state r_state;
    mapid_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mapid_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mapid_pkg::ST_IDLE:     if (i_s_tvalid) n_state = mapid_pkg::ST_TGT_MUL;
            mapid_pkg::ST_TGT_MUL:  n_state = mapid_pkg::ST_TGT_DIV;
            mapid_pkg::ST_TGT_DIV:  n_state = mapid_pkg::ST_TGT_WAIT;
            mapid_pkg::ST_TGT_WAIT: if (i_sts.div_done) n_state = mapid_pkg::ST_ERR;
            mapid_pkg::ST_ERR:      n_state = mapid_pkg::ST_INTEG;
            mapid_pkg::ST_INTEG:    n_state = mapid_pkg::ST_DER_WAIT;
            mapid_pkg::ST_DER_WAIT: begin
                if (i_sts.dt_zero || i_sts.div_done) n_state = mapid_pkg::ST_MUL_P;
            end
            mapid_pkg::ST_MUL_P:    n_state = mapid_pkg::ST_MUL_ILO;
            mapid_pkg::ST_MUL_ILO:  n_state = mapid_pkg::ST_MUL_IHI;
            mapid_pkg::ST_MUL_IHI:  n_state = mapid_pkg::ST_MUL_D;
            mapid_pkg::ST_MUL_D:    n_state = mapid_pkg::ST_ACC_D;
            mapid_pkg::ST_ACC_D:    n_state = mapid_pkg::ST_CLAMP;
            mapid_pkg::ST_CLAMP:    n_state = mapid_pkg::ST_DONE;
            mapid_pkg::ST_DONE:     if (i_sts.out_free) n_state = mapid_pkg::ST_IDLE;
            default:                n_state = mapid_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.mul_sel    = mapid_pkg::MUL_NONE;
        o_cmd.acc_op     = mapid_pkg::ACC_HOLD;
        o_cmd.div_sel    = mapid_pkg::DIV_TGT;
        o_s_tready       = 1'b0;
        case (r_state)
            mapid_pkg::ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            mapid_pkg::ST_TGT_MUL: begin
                o_cmd.mul_sel = mapid_pkg::MUL_TGT;
            end
            mapid_pkg::ST_TGT_DIV: begin
                o_cmd.div_start = 1'b1;
            end
            mapid_pkg::ST_TGT_WAIT: begin
                o_cmd.err_load = i_sts.div_done;
            end
            mapid_pkg::ST_ERR: begin
                o_cmd.mul_sel   = mapid_pkg::MUL_ERR;
                o_cmd.div_sel   = mapid_pkg::DIV_DER;
                o_cmd.div_start = !i_sts.dt_zero;
            end
            mapid_pkg::ST_INTEG: begin
                o_cmd.integ_load = 1'b1;
            end
            mapid_pkg::ST_DER_WAIT: begin
                o_cmd.d_load = i_sts.dt_zero || i_sts.div_done;
            end
            mapid_pkg::ST_MUL_P: begin
                o_cmd.mul_sel = mapid_pkg::MUL_P;
            end
            mapid_pkg::ST_MUL_ILO: begin
                o_cmd.mul_sel = mapid_pkg::MUL_ILO;
                o_cmd.acc_op  = mapid_pkg::ACC_LOAD;
            end
            mapid_pkg::ST_MUL_IHI: begin
                o_cmd.mul_sel = mapid_pkg::MUL_IHI;
                o_cmd.acc_op  = mapid_pkg::ACC_ADD;
            end
            mapid_pkg::ST_MUL_D: begin
                o_cmd.mul_sel = mapid_pkg::MUL_D;
                o_cmd.acc_op  = mapid_pkg::ACC_ADD_HI;
            end
            mapid_pkg::ST_ACC_D: begin
                o_cmd.acc_op = mapid_pkg::ACC_ADD;
            end
            mapid_pkg::ST_CLAMP: begin
                o_cmd.clamp_load = 1'b1;
            end
            mapid_pkg::ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/motor_angle_pid.sv =====
// ----------------------------------------------------------------------------
// motor_angle_pid
// PID position controller: encoder count and timer in, direction pins,
// PWM duty and settled flag out.
// ----------------------------------------------------------------------------
// Requests: a new request is accepted only in the idle state, after the result
//   of the last one is loaded into the output register; the derivative divide
//   is skipped when the timer has not advanced since the last request. Each
//   request makes one pass, or two, through the radix-4 divider.
// Reset: synchronous, active low; config returns to defaults, loop state
//   (previous error, integral, time stamps) clears to zero.
// ----------------------------------------------------------------------------
module motor_angle_pid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [mapid_pkg::S_DATA_W-1:0]      i_s_axis_tdata,  // encoder_count, timer_count
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mapid_pkg::M_DATA_W-1:0]      o_m_axis_tdata,  // dir_a, dir_b, pwm_duty, settled
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mapid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    mapid_pkg::t_cmd w_cmd;
    mapid_pkg::t_sts w_sts;
    logic            w_s_accept;

    assign o_cfg_ready = 1'b1;
    assign w_s_accept  = i_s_axis_tvalid && o_s_axis_tready;

    mapid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mapid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_enc       (i_s_axis_tdata[15:0]),
        .i_now       (i_s_axis_tdata[31:16]),
        .i_m_tready  (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata)
    );

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !o_s_axis_tready
    ) else $error("input ready right after an accepted request");

    a_dir_not_both_low: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[0] || o_m_axis_tdata[1])
    ) else $error("both direction pins low");

    a_div_done_clears: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !w_sts.div_done
    ) else $error("divider done flag not cleared by start");

    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free
    ) else $error("result loaded over a pending result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_angle_pid. Control ticks go in on the slave
// stream and drive results come out on the master stream; a cycle-free
// integer model of the PID law predicts every result, and each one is
// compared field by field. Directed corner ticks come first, then random
// phases that track a target, hit the block with raw values, and finally
// wind the integral up into saturation. Both streams idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import mapid_pkg::*;

    localparam int    LIMIT    = 400000;
    localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO = -INTEG_HI - 1;
    localparam longint IB_LIM   = 64'sh0000_0400_0000_0000;
    localparam longint U_LIM    = 64'sd16776960;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic        dir_a;
        logic        dir_b;
        logic [15:0] pwm_duty;
        logic        settled;
    } drive_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
    } reg_write_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata = '0;  // encoder_count, timer_count
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;       // dir_a, dir_b, pwm_duty, settled
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // model copy of the registers and loop state
    int          m_gain_p = 256;
    int          m_gain_i = 0;
    int          m_gain_d = 0;
    int          m_target = 0;
    int          m_ppr = 360;
    int          m_min_duty = 0;
    int          m_max_duty = 65535;
    logic [31:0] m_timeout = '0;
    longint      m_prev_err = 0;
    longint      m_integ = 0;
    logic [15:0] m_prev_time = '0;
    logic [15:0] m_last_zero = '0;

    logic [S_DATA_W-1:0] tick_queue[$];
    drive_t              drive_queue[$];
    reg_write_t          reg_writes[$];

    idle_mode_t idle_mode = IDLE_NONE;
    int         tnow = 0;
    int         n_pushed = 0;
    int         n_ticks = 0;
    int         n_checked = 0;
    int         n_writes = 0;
    int         n_errors = 0;
    int         cycles = 0;

    motor_angle_pid dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic drive_t compute_drive(input logic [15:0] enc, input logic [15:0] now);
        longint      tgt, err, dtl, deriv, ib, u, y, mag;
        logic [15:0] dt, since_zero;
        drive_t      r;
        tgt = (longint'(m_target) * longint'(m_ppr)) / 360;
        err = tgt - longint'(enc);
        dt = now - m_prev_time;
        dtl = longint'(dt);
        m_integ = m_integ + err * dtl;
        if (m_integ > INTEG_HI) m_integ = INTEG_HI;
        if (m_integ < INTEG_LO) m_integ = INTEG_LO;
        deriv = (dt != 16'd0) ? (err - m_prev_err) / dtl : 64'sd0;
        ib = m_integ;
        if (ib > IB_LIM) ib = IB_LIM;
        if (ib < -IB_LIM) ib = -IB_LIM;
        u = longint'(m_gain_p) * err + longint'(m_gain_i) * ib + longint'(m_gain_d) * deriv;
        if (u > U_LIM) begin
            u = U_LIM;
        end else if (u < -U_LIM) begin
            u = -U_LIM;
        end else if (u == 0) begin
            m_last_zero = now;
        end
        y = u / 256;
        r.dir_a = (y >= 0);
        r.dir_b = (y <= 0);
        mag = (y < 0) ? -y : y;
        if (mag < m_min_duty) mag = m_min_duty;
        if (mag > m_max_duty) mag = m_max_duty;
        r.pwm_duty = mag[15:0];
        m_prev_err = err;
        m_prev_time = now;
        since_zero = now - m_last_zero;
        r.settled = ({16'd0, since_zero} < m_timeout);
        return r;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_GAIN_P:  m_gain_p = int'(data[15:0]);
            CFG_GAIN_I:  m_gain_i = int'(data[15:0]);
            CFG_GAIN_D:  m_gain_d = int'(data[15:0]);
            CFG_TGT_ANG: m_target = int'($signed(data[15:0]));
            CFG_PPR:     m_ppr = int'(data[15:0]);
            CFG_MIN_DTY: m_min_duty = int'(data[15:0]);
            CFG_MAX_DTY: m_max_duty = int'(data[15:0]);
            CFG_ZERO_TO: m_timeout = data;
            default: ;
        endcase
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        reg_write_t w;
        w.idx = idx;
        w.data = data;
        reg_writes.push_back(w);
    endfunction

    function automatic void add_tick(input int enc, input int dt);
        tnow = (tnow + dt) & 32'h0000_FFFF;
        tick_queue.push_back({tnow[15:0], enc[15:0]});
        n_pushed++;
    endfunction

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 74;
            IDLE_BOTH: return $urandom_range(0, 99) < 16;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 74;
            IDLE_BOTH: return $urandom_range(0, 99) < 16;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic int pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 75) return $urandom_range(1, 30);
        if (r < 93) return $urandom_range(31, 2000);
        return $urandom_range(0, 65535);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        n_errors++;
    endtask

    // config writes go out back to back; valid drops only after the last one
    task automatic write_regs();
        reg_write_t w;
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data <= w.data;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            apply_reg(w.idx, w.data);
            n_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_ticks != n_pushed || drive_queue.size() != 0) @(posedge clk);
    endtask

    task automatic run_track(input idle_mode_t mode, input int gi_max, input int count);
        longint tgt;
        int     enc;
        idle_mode = mode;
        set_reg(CFG_GAIN_P, $urandom_range(0, 2048));
        set_reg(CFG_GAIN_I, $urandom_range(0, gi_max));
        set_reg(CFG_GAIN_D, $urandom_range(0, 4096));
        set_reg(CFG_TGT_ANG, $urandom_range(0, 720));
        case ($urandom_range(0, 4))
            0:       set_reg(CFG_PPR, 360);
            1:       set_reg(CFG_PPR, 1000);
            2:       set_reg(CFG_PPR, 1024);
            3:       set_reg(CFG_PPR, 4096);
            default: set_reg(CFG_PPR, $urandom_range(1, 5000));
        endcase
        set_reg(CFG_MIN_DTY, $urandom_range(0, 200));
        set_reg(CFG_MAX_DTY, $urandom_range(300, 65535));
        case ($urandom_range(0, 4))
            0:       set_reg(CFG_ZERO_TO, 32'd0);
            1:       set_reg(CFG_ZERO_TO, $urandom_range(1, 300));
            2:       set_reg(CFG_ZERO_TO, 32'd65535);
            3:       set_reg(CFG_ZERO_TO, 32'd65536);
            default: set_reg(CFG_ZERO_TO, 32'hFFFF_FFFF);
        endcase
        write_regs();
        repeat (count) begin
            tgt = (longint'(m_target) * longint'(m_ppr)) / 360;
            enc = int'(tgt);
            if ($urandom_range(0, 99) >= 30) enc = enc + int'($urandom_range(0, 600)) - 300;
            if (enc < 0) enc = 0;
            if (enc > 65535) enc = 65535;
            add_tick(enc, pick_dt());
        end
        wait_drained();
    endtask

    task automatic run_wide(input idle_mode_t mode, input int count);
        idle_mode = mode;
        set_reg(CFG_GAIN_P, $urandom_range(0, 65535));
        set_reg(CFG_GAIN_I, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535));
        set_reg(CFG_GAIN_D, $urandom_range(0, 65535));
        set_reg(CFG_TGT_ANG, $urandom_range(0, 65535));
        set_reg(CFG_PPR, $urandom_range(0, 65535));
        set_reg(CFG_MIN_DTY, $urandom_range(0, 65535));
        set_reg(CFG_MAX_DTY, $urandom_range(0, 65535));
        set_reg(CFG_ZERO_TO, $urandom());
        write_regs();
        repeat (count) add_tick($urandom_range(0, 65535), $urandom_range(0, 65535));
        wait_drained();
    endtask

    // large negative error over long gaps drives the integral to its floor
    task automatic run_windup(input idle_mode_t mode, input int count);
        idle_mode = mode;
        set_reg(CFG_GAIN_P, $urandom_range(0, 65535));
        set_reg(CFG_GAIN_I, $urandom_range(1, 65535));
        set_reg(CFG_GAIN_D, $urandom_range(0, 65535));
        set_reg(CFG_TGT_ANG, 32'h0000_8000);
        set_reg(CFG_PPR, 32'd65535);
        set_reg(CFG_MIN_DTY, 32'd0);
        set_reg(CFG_MAX_DTY, 32'd65535);
        set_reg(CFG_ZERO_TO, 32'hFFFF_FFFF);
        write_regs();
        repeat (count) add_tick(65535 - $urandom_range(0, 15), $urandom_range(60000, 65535));
        repeat (20) add_tick($urandom_range(0, 65535), $urandom_range(0, 65535));
        wait_drained();
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                drive_queue.push_back(compute_drive(s_tdata[15:0], s_tdata[31:16]));
                n_ticks++;
            end
            if (!s_valid || s_ready) begin
                if (tick_queue.size() != 0 && !send_gap()) begin
                    s_tdata <= tick_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        drive_t want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_queue.size() == 0) begin
                    report_mismatch("result with no request pending", longint'(m_tdata), 0);
                end else begin
                    want = drive_queue.pop_front();
                    if (m_tdata[0] !== want.dir_a)
                        report_mismatch("dir_a", m_tdata[0], want.dir_a);
                    if (m_tdata[1] !== want.dir_b)
                        report_mismatch("dir_b", m_tdata[1], want.dir_b);
                    if (m_tdata[17:2] !== want.pwm_duty)
                        report_mismatch("pwm_duty", m_tdata[17:2], want.pwm_duty);
                    if (m_tdata[18] !== want.settled)
                        report_mismatch("settled", m_tdata[18], want.settled);
                    if (m_tdata[M_DATA_W-1:19] !== '0)
                        report_mismatch("tdata pad bits", m_tdata[M_DATA_W-1:19], 0);
                    n_checked++;
                end
            end
            m_ready <= !recv_stall();
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     drive_queue.size());
            $display("FAIL motor_angle_pid");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: zero and negative error, dt of zero, timer extremes
        add_tick(0, 0);
        add_tick(100, 10);
        add_tick(65535, 0);
        add_tick(0, 65525);
        add_tick(5, 0);
        add_tick(0, 101);
        wait_drained();

        // unit gain, zero pulses per rev: sub-unit outputs and exact zero
        set_reg(CFG_GAIN_P, 32'd1);
        set_reg(CFG_TGT_ANG, 32'd1234);
        set_reg(CFG_PPR, 32'd0);
        set_reg(CFG_ZERO_TO, 32'hFFFF_FFFF);
        write_regs();
        add_tick(100, 5);
        add_tick(0, 3);
        add_tick(256, 0);
        add_tick(255, 1);
        add_tick(65535, 1);
        wait_drained();

        // full gains, extreme target, min duty above max duty
        set_reg(CFG_GAIN_P, 32'd65535);
        set_reg(CFG_GAIN_I, 32'd65535);
        set_reg(CFG_GAIN_D, 32'd65535);
        set_reg(CFG_TGT_ANG, 32'h0000_7FFF);
        set_reg(CFG_PPR, 32'd65535);
        set_reg(CFG_MIN_DTY, 32'd65535);
        set_reg(CFG_MAX_DTY, 32'd0);
        set_reg(CFG_ZERO_TO, 32'd1);
        write_regs();
        add_tick(0, 0);
        add_tick(65535, 0);
        add_tick(12345, 0);
        wait_drained();
        set_reg(CFG_TGT_ANG, 32'h0000_8000);
        write_regs();
        add_tick(65535, 0);
        add_tick(0, 0);
        wait_drained();

        // derivative only, duty window, settle window
        set_reg(CFG_GAIN_P, 32'd0);
        set_reg(CFG_GAIN_I, 32'd0);
        set_reg(CFG_TGT_ANG, 32'd0);
        set_reg(CFG_PPR, 32'd360);
        set_reg(CFG_MIN_DTY, 32'd10);
        set_reg(CFG_MAX_DTY, 32'd1000);
        set_reg(CFG_ZERO_TO, 32'd100);
        write_regs();
        add_tick(0, 1);
        add_tick(50, 2);
        add_tick(50, 0);
        add_tick(51, 7);
        add_tick(60, 3);
        add_tick(0, 500);
        wait_drained();

        run_track(IDLE_SEND, 0, 50);
        run_track(IDLE_RECV, 3, 50);
        run_track(IDLE_BOTH, 0, 50);
        run_track(IDLE_NONE, 2, 50);
        run_wide(IDLE_SEND, 50);
        run_wide(IDLE_RECV, 50);
        run_windup(IDLE_BOTH, 370);

        repeat (60) @(posedge clk);
        $display("ran %0d control ticks through tracking, raw and wind-up phases", n_ticks);
        $display("checked %0d drive results after %0d register writes, %0d mismatches",
                 n_checked, n_writes, n_errors);
        if (n_errors == 0) begin
            $display("PASS motor_angle_pid");
        end else begin
            $display("FAIL motor_angle_pid");
        end
        $finish;
    end

endmodule
